// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/gpx_pkg.sv
// ---------------------------------------------------------------------------
// gpx_pkg
// Constants, codes and beat types of the GPIO expander shadow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpx_pkg;

    localparam int NUM_BANKS  = 5;
    localparam int NUM_PINS   = NUM_BANKS * 8;
    localparam int LEVELS_W   = 40;
    localparam int WIDE_W     = (NUM_PINS > LEVELS_W) ? NUM_PINS : LEVELS_W;
    localparam int KIND_W     = 4;
    localparam int BANK_W     = 3;
    localparam int PIN_W      = 6;
    localparam int ITYPE_W    = 3;
    localparam int REG_W      = 5;
    localparam int BANK_IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int PIN_IDX_W  = $clog2(NUM_PINS);

    localparam logic [KIND_W-1:0] KIND_DIR_IN  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_DIR_OUT = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SET     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_INVERT  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_READ    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ATTACH  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_DETACH  = 4'd8;

    localparam logic [ITYPE_W-1:0] IRQ_DISABLE = 3'd0;
    localparam logic [ITYPE_W-1:0] IRQ_RISING  = 3'd1;
    localparam logic [ITYPE_W-1:0] IRQ_FALLING = 3'd2;
    localparam logic [ITYPE_W-1:0] IRQ_ANY     = 3'd3;
    localparam logic [ITYPE_W-1:0] IRQ_LOW     = 3'd4;
    localparam logic [ITYPE_W-1:0] IRQ_HIGH    = 3'd5;

    localparam logic [REG_W-1:0] REG_LEVEL_BASE = 5'h08;
    localparam logic [REG_W-1:0] REG_DIR_BASE   = 5'h18;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BANK_W-1:0]   bank;
        logic [7:0]          mask;
        logic [LEVELS_W-1:0] pin_levels;
        logic [PIN_W-1:0]    pin;
        logic [ITYPE_W-1:0]  irq_type;
    } gpx_item_t;

    typedef struct packed {
        logic                bus_write_valid;
        logic [REG_W-1:0]    bus_reg;
        logic [7:0]          bus_data;
        logic [7:0]          read_value;
        logic [LEVELS_W-1:0] fire_mask;
        logic [LEVELS_W-1:0] all_levels;
    } gpx_result_t;

    function automatic logic pin_fires(
        input logic               attached,
        input logic [ITYPE_W-1:0] itype,
        input logic               old_level,
        input logic               cur_level
    );
        logic hit;
        begin
            hit = 1'b0;
            case (itype)
                IRQ_RISING, IRQ_HIGH: hit = cur_level & ~old_level;
                IRQ_FALLING, IRQ_LOW: hit = ~cur_level & old_level;
                IRQ_ANY:              hit = cur_level ^ old_level;
                default:              hit = 1'b0;
            endcase
            return attached & hit;
        end
    endfunction

endpackage

// File: hw/rtl/gpx_if.sv
// ---------------------------------------------------------------------------
// gpx_if
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpx_in_if
    import gpx_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BANK_W-1:0]   bank;
    logic [7:0]          mask;
    logic [LEVELS_W-1:0] pin_levels;
    logic [PIN_W-1:0]    pin;
    logic [ITYPE_W-1:0]  irq_type;

    modport source (output valid, kind, bank, mask, pin_levels, pin, irq_type, input ready);
    modport sink   (input valid, kind, bank, mask, pin_levels, pin, irq_type, output ready);
endinterface

interface gpx_out_if
    import gpx_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                bus_write_valid;
    logic [REG_W-1:0]    bus_reg;
    logic [7:0]          bus_data;
    logic [7:0]          read_value;
    logic [LEVELS_W-1:0] fire_mask;
    logic [LEVELS_W-1:0] all_levels;

    modport source (output valid, bus_write_valid, bus_reg, bus_data, read_value, fire_mask,
                    all_levels, input ready);
    modport sink   (input valid, bus_write_valid, bus_reg, bus_data, read_value, fire_mask,
                    all_levels, output ready);
endinterface

// File: hw/rtl/gpx_state.sv
// ---------------------------------------------------------------------------
// gpx_state
// Shadow registers of the expander and the per-beat update and result logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpx_state
    import gpx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  gpx_item_t   item,
    output gpx_result_t result
);

    logic [7:0]         dir_reg   [NUM_BANKS];
    logic [7:0]         dir_next  [NUM_BANKS];
    logic [7:0]         level_reg [NUM_BANKS];
    logic [7:0]         level_next[NUM_BANKS];
    logic [ITYPE_W-1:0] type_reg  [NUM_PINS];
    logic [ITYPE_W-1:0] type_next [NUM_PINS];
    logic [NUM_PINS-1:0] att_reg;
    logic [NUM_PINS-1:0] att_next;

    logic                  bank_ok;
    logic                  pin_ok;
    logic [BANK_IDX_W-1:0] bidx;
    logic [PIN_IDX_W-1:0]  pidx;
    logic [7:0]            new_byte;
    logic [WIDE_W-1:0]     cur_wide;
    logic [WIDE_W-1:0]     old_wide;
    logic [WIDE_W-1:0]     new_wide;
    logic [WIDE_W-1:0]     fire_wide;

    assign bank_ok  = {1'b0, item.bank} < (BANK_W + 1)'(NUM_BANKS);
    assign pin_ok   = {1'b0, item.pin} < (PIN_W + 1)'(NUM_PINS);
    assign bidx     = item.bank[BANK_IDX_W-1:0];
    assign pidx     = item.pin[PIN_IDX_W-1:0];
    assign cur_wide = WIDE_W'(item.pin_levels);

    always_comb
    begin
        old_wide = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            old_wide[b*8 +: 8] = level_reg[b];
        end
    end

    always_comb
    begin
        dir_next   = dir_reg;
        level_next = level_reg;
        type_next  = type_reg;
        att_next   = att_reg;
        new_byte   = '0;
        fire_wide  = '0;
        result     = '0;
        case (item.kind)
            KIND_DIR_IN, KIND_DIR_OUT:
            begin
                if (bank_ok)
                begin
                    new_byte = (item.kind == KIND_DIR_IN) ? (dir_reg[bidx] | item.mask)
                                                          : (dir_reg[bidx] & ~item.mask);
                    dir_next[bidx]         = new_byte;
                    result.bus_write_valid = 1'b1;
                    result.bus_reg         = REG_DIR_BASE + REG_W'(item.bank);
                    result.bus_data        = new_byte;
                end
            end
            KIND_SET, KIND_CLEAR, KIND_INVERT:
            begin
                if (bank_ok)
                begin
                    if (item.kind == KIND_SET)
                        new_byte = level_reg[bidx] | item.mask;
                    else if (item.kind == KIND_CLEAR)
                        new_byte = level_reg[bidx] & ~item.mask;
                    else
                        new_byte = level_reg[bidx] ^ item.mask;
                    level_next[bidx]       = new_byte;
                    result.bus_write_valid = 1'b1;
                    result.bus_reg         = REG_LEVEL_BASE + REG_W'(item.bank);
                    result.bus_data        = new_byte;
                end
            end
            KIND_READ:
            begin
                if (bank_ok)
                    result.read_value = level_reg[bidx] & item.mask;
            end
            KIND_SAMPLE:
            begin
                for (int p = 0; p < NUM_PINS; p++)
                begin
                    fire_wide[p] = pin_fires(att_reg[p], type_reg[p], old_wide[p], cur_wide[p]);
                end
                for (int b = 0; b < NUM_BANKS; b++)
                begin
                    level_next[b] = cur_wide[b*8 +: 8];
                end
                result.fire_mask = fire_wide[LEVELS_W-1:0];
            end
            KIND_ATTACH:
            begin
                if (pin_ok)
                begin
                    type_next[pidx] = item.irq_type;
                    att_next[pidx]  = (item.irq_type != IRQ_DISABLE);
                end
            end
            KIND_DETACH:
            begin
                if (pin_ok)
                    att_next[pidx] = 1'b0;
            end
            default:
            begin
            end
        endcase
        new_wide = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            new_wide[b*8 +: 8] = level_next[b];
        end
        result.all_levels = new_wide[LEVELS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                dir_reg[b]   <= '0;
                level_reg[b] <= '0;
            end
            for (int p = 0; p < NUM_PINS; p++)
            begin
                type_reg[p] <= IRQ_DISABLE;
            end
            att_reg <= '0;
        end
        else if (en)
        begin
            dir_reg   <= dir_next;
            level_reg <= level_next;
            type_reg  <= type_next;
            att_reg   <= att_next;
        end
    end

endmodule

// File: hw/rtl/gpio_expander_shadow_irq.sv
// ---------------------------------------------------------------------------
// gpio_expander_shadow_irq
// Shadow of a banked GPIO expander with per-pin change interrupts.
// ---------------------------------------------------------------------------
// Every command beat yields exactly one result beat. The block takes one beat
// per cycle while the sink keeps taking results: a beat is captured in the
// input register, then applied to the shadow state and resolved into its
// result as it moves into the output register, where the result sits until
// the sink takes it. Mask commands on a valid bank return the device register
// write (level at 0x08 plus bank, direction at 0x18 plus bank); a sample
// returns the attached pins that fire against the stored levels, then stores them.
`timescale 1ns / 1ps

module gpio_expander_shadow_irq
    import gpx_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    gpx_in_if.sink  item,
    gpx_out_if.source result
);

    gpx_item_t   item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    gpx_result_t result_reg;
    gpx_result_t result_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    logic        in_accept;
    logic        advance;

    assign advance           = item_valid_reg & (~result_valid_reg | result.ready);
    assign item.ready        = ~item_valid_reg | advance;
    assign in_accept         = item.valid & item.ready;
    assign item_valid_next   = in_accept | (item_valid_reg & ~advance);
    assign result_valid_next = advance | (result_valid_reg & ~result.ready);

    gpx_state u_gpx_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // capture beat and load result register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.kind       <= item.kind;
            item_reg.bank       <= item.bank;
            item_reg.mask       <= item.mask;
            item_reg.pin_levels <= item.pin_levels;
            item_reg.pin        <= item.pin;
            item_reg.irq_type   <= item.irq_type;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign result.valid           = result_valid_reg;
    assign result.bus_write_valid = result_reg.bus_write_valid;
    assign result.bus_reg         = result_reg.bus_reg;
    assign result.bus_data        = result_reg.bus_data;
    assign result.read_value      = result_reg.read_value;
    assign result.fire_mask       = result_reg.fire_mask;
    assign result.all_levels      = result_reg.all_levels;

endmodule

// File: hw/rtl/gpx_checker.sv
// ---------------------------------------------------------------------------
// gpx_checker
// Port-level checks on the result channel of the expander shadow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpx_checker
    import gpx_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic                bus_write_valid,
    input logic [REG_W-1:0]    bus_reg,
    input logic [7:0]          bus_data,
    input logic [7:0]          read_value,
    input logic [LEVELS_W-1:0] fire_mask
);

    `ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && !out_ready, out_valid && $stable(bus_data) && $stable(fire_mask))
    `ASSERT_IMPLIES(a_idle_bus_zero, clk, rst_n, out_valid && !bus_write_valid, bus_reg == '0 && bus_data == '0)
    `ASSERT_IMPLIES(a_write_exclusive, clk, rst_n, out_valid && bus_write_valid, read_value == '0 && fire_mask == '0 && (bus_reg[4:3] == 2'b01 || bus_reg[4:3] == 2'b11))

endmodule

bind gpio_expander_shadow_irq gpx_checker u_gpx_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .bus_write_valid (result.bus_write_valid),
    .bus_reg         (result.bus_reg),
    .bus_data        (result.bus_data),
    .read_value      (result.read_value),
    .fire_mask       (result.fire_mask)
);

// File: tb/gpio_expander_shadow_irq_test.sv
// ---------------------------------------------------------------------------
// gpio_expander_shadow_irq_test
// Drives command and sample beats into the GPIO expander shadow and checks
// every result beat against a cycle-free shadow predictor held in a small
// scoreboard class. A directed opener covers the edge cases, then random
// traffic runs under three back-pressure profiles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import gpx_pkg::*;

class shadow_scoreboard;

    logic [7:0]         dir_q [NUM_BANKS];
    logic [7:0]         lvl_q [NUM_BANKS];
    logic [ITYPE_W-1:0] itype_q [NUM_PINS];
    logic               att_q [NUM_PINS];
    gpx_result_t        pending_results [$];
    int                 n_items;
    int                 n_results;
    int                 n_fires;
    int                 n_writes;
    int                 n_fail;

    function new();
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            dir_q[b] = '0;
            lvl_q[b] = '0;
        end
        for (int p = 0; p < NUM_PINS; p++)
        begin
            itype_q[p] = IRQ_DISABLE;
            att_q[p]   = 1'b0;
        end
        n_items   = 0;
        n_results = 0;
        n_fires   = 0;
        n_writes  = 0;
        n_fail    = 0;
    endfunction

    function logic [LEVELS_W-1:0] levels();
        logic [LEVELS_W-1:0] v;
        v = '0;
        for (int b = 0; b < NUM_BANKS; b++)
            v[8*b +: 8] = lvl_q[b];
        return v;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void note_item(gpx_item_t it);
        gpx_result_t         r;
        logic [LEVELS_W-1:0] old_lv;
        logic                o;
        logic                c;
        logic                hit;
        logic                bank_ok;
        int                  b;
        r       = '0;
        b       = int'(it.bank);
        bank_ok = (int'(it.bank) < NUM_BANKS);
        case (it.kind)
            KIND_DIR_IN, KIND_DIR_OUT:
                if (bank_ok)
                begin
                    if (it.kind == KIND_DIR_IN)
                        dir_q[b] = dir_q[b] | it.mask;
                    else
                        dir_q[b] = dir_q[b] & ~it.mask;
                    r.bus_write_valid = 1'b1;
                    r.bus_reg         = REG_DIR_BASE + REG_W'(it.bank);
                    r.bus_data        = dir_q[b];
                end
            KIND_SET, KIND_CLEAR, KIND_INVERT:
                if (bank_ok)
                begin
                    if (it.kind == KIND_SET)
                        lvl_q[b] = lvl_q[b] | it.mask;
                    else if (it.kind == KIND_CLEAR)
                        lvl_q[b] = lvl_q[b] & ~it.mask;
                    else
                        lvl_q[b] = lvl_q[b] ^ it.mask;
                    r.bus_write_valid = 1'b1;
                    r.bus_reg         = REG_LEVEL_BASE + REG_W'(it.bank);
                    r.bus_data        = lvl_q[b];
                end
            KIND_READ:
                if (bank_ok)
                    r.read_value = lvl_q[b] & it.mask;
            KIND_SAMPLE:
            begin
                old_lv = levels();
                for (int p = 0; p < NUM_PINS; p++)
                begin
                    o   = old_lv[p];
                    c   = it.pin_levels[p];
                    hit = 1'b0;
                    case (itype_q[p])
                        IRQ_RISING, IRQ_HIGH: hit = c & ~o;
                        IRQ_FALLING, IRQ_LOW: hit = ~c & o;
                        IRQ_ANY:              hit = c ^ o;
                        default:              hit = 1'b0;
                    endcase
                    r.fire_mask[p] = att_q[p] & hit;
                end
                for (int k = 0; k < NUM_BANKS; k++)
                    lvl_q[k] = it.pin_levels[8*k +: 8];
            end
            KIND_ATTACH:
                if (int'(it.pin) < NUM_PINS)
                begin
                    itype_q[it.pin] = it.irq_type;
                    att_q[it.pin]   = (it.irq_type != IRQ_DISABLE);
                end
            KIND_DETACH:
                if (int'(it.pin) < NUM_PINS)
                    att_q[it.pin] = 1'b0;
            default:
                ;
        endcase
        r.all_levels = levels();
        pending_results.push_back(r);
        n_items++;
    endfunction

    function void flag(string what, logic [LEVELS_W-1:0] exp_v, logic [LEVELS_W-1:0] act_v);
        n_fail++;
        if (n_fail <= 10)
            $display("[%0t] mismatch %s: expected %h actual %h", $realtime, what, exp_v, act_v);
    endfunction

    function void compare_field(string what, logic [LEVELS_W-1:0] exp_v,
                                logic [LEVELS_W-1:0] act_v);
        if (exp_v !== act_v)
            flag(what, exp_v, act_v);
    endfunction

    function void check_result(gpx_result_t act);
        gpx_result_t e;
        n_results++;
        if (pending_results.size() == 0)
        begin
            flag("result beat with nothing pending", '0, act.all_levels);
            return;
        end
        e = pending_results.pop_front();
        if (e.bus_write_valid)
            n_writes++;
        if (e.fire_mask != '0)
            n_fires++;
        compare_field("bus_write_valid", LEVELS_W'(e.bus_write_valid),
                      LEVELS_W'(act.bus_write_valid));
        compare_field("bus_reg", LEVELS_W'(e.bus_reg), LEVELS_W'(act.bus_reg));
        compare_field("bus_data", LEVELS_W'(e.bus_data), LEVELS_W'(act.bus_data));
        compare_field("read_value", LEVELS_W'(e.read_value), LEVELS_W'(act.read_value));
        compare_field("fire_mask", e.fire_mask, act.fire_mask);
        compare_field("all_levels", e.all_levels, act.all_levels);
    endfunction

endclass

module gpio_expander_shadow_irq_test;

    localparam logic [KIND_W-1:0]  KIND_SPARE_FIRST = 4'd9;
    localparam logic [KIND_W-1:0]  KIND_SPARE_LAST  = 4'd15;
    localparam logic [ITYPE_W-1:0] IRQ_SPARE_A      = 3'd6;
    localparam logic [ITYPE_W-1:0] IRQ_SPARE_B      = 3'd7;
    localparam int                 PHASE_ITEMS      = 320;

    logic clk;
    logic rst_n;
    int   src_idle;
    int   snk_idle;

    shadow_scoreboard sb;

    gpx_in_if  item_ch ();
    gpx_out_if result_ch ();

    gpio_expander_shadow_irq u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic gpx_item_t mk(logic [KIND_W-1:0] k, logic [BANK_W-1:0] b,
                                     logic [7:0] m, logic [LEVELS_W-1:0] lv,
                                     logic [PIN_W-1:0] p, logic [ITYPE_W-1:0] t);
        gpx_item_t it;
        it.kind       = k;
        it.bank       = b;
        it.mask       = m;
        it.pin_levels = lv;
        it.pin        = p;
        it.irq_type   = t;
        return it;
    endfunction

    function automatic gpx_item_t random_item();
        gpx_item_t           it;
        logic [63:0]         w;
        logic [63:0]         toggles;
        int                  roll;
        w             = {$urandom, $urandom};
        it.kind       = KIND_W'($urandom_range(15));
        it.bank       = ($urandom_range(9) < 9) ? BANK_W'($urandom_range(NUM_BANKS - 1))
                                                : BANK_W'($urandom_range(7, NUM_BANKS));
        it.mask       = 8'($urandom);
        it.pin_levels = w[LEVELS_W-1:0];
        it.pin        = ($urandom_range(9) < 9) ? PIN_W'($urandom_range(NUM_PINS - 1))
                                                : PIN_W'($urandom_range(63, NUM_PINS));
        it.irq_type   = ITYPE_W'($urandom_range(7));
        roll          = $urandom_range(99);
        if (roll < 6)
            it.kind = KIND_W'($urandom_range(int'(KIND_SPARE_LAST), int'(KIND_SPARE_FIRST)));
        else if (roll < 32)
        begin
            it.kind = KIND_SAMPLE;
            if ($urandom_range(3) != 0)
            begin
                toggles       = {$urandom, $urandom} & {$urandom, $urandom}
                                & {$urandom, $urandom};
                it.pin_levels = sb.levels() ^ toggles[LEVELS_W-1:0];
            end
        end
        else if (roll < 48)
            it.kind = KIND_ATTACH;
        else if (roll < 53)
            it.kind = KIND_DETACH;
        else
            it.kind = KIND_W'($urandom_range(int'(KIND_READ), int'(KIND_DIR_IN)));
        return it;
    endfunction

    task automatic send_item(gpx_item_t it);
        while ($urandom_range(99) < src_idle)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= it.kind;
        item_ch.bank       <= it.bank;
        item_ch.mask       <= it.mask;
        item_ch.pin_levels <= it.pin_levels;
        item_ch.pin        <= it.pin;
        item_ch.irq_type   <= it.irq_type;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    task automatic run_random(int n_beats, int src_pct, int snk_pct, bit hold_mid);
        src_idle = src_pct;
        snk_idle = snk_pct;
        for (int i = 0; i < n_beats; i++)
        begin
            if (hold_mid && i == n_beats / 2)
            begin
                item_ch.valid <= 1'b0;
                while (sb.pending() != 0)
                    @(negedge clk);
            end
            send_item(random_item());
        end
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial
    begin
        gpx_result_t act;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                act.bus_write_valid = result_ch.bus_write_valid;
                act.bus_reg         = result_ch.bus_reg;
                act.bus_data        = result_ch.bus_data;
                act.read_value      = result_ch.read_value;
                act.fire_mask       = result_ch.fire_mask;
                act.all_levels      = result_ch.all_levels;
                sb.check_result(act);
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("timeout waiting for result beats");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int guard;
        sb                  = new();
        src_idle            = 0;
        snk_idle            = 0;
        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_DIR_IN;
        item_ch.bank        <= '0;
        item_ch.mask        <= '0;
        item_ch.pin_levels  <= '0;
        item_ch.pin         <= '0;
        item_ch.irq_type    <= IRQ_DISABLE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(mk(KIND_DIR_IN,  0, 8'hFF, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_DIR_OUT, 0, 8'h0F, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_DIR_IN,  BANK_W'(NUM_BANKS - 1), 8'hA5, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_SET,     0, 8'hFF, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_CLEAR,   0, 8'hF0, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_INVERT,  BANK_W'(NUM_BANKS - 1), 8'hFF, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_READ,    BANK_W'(NUM_BANKS - 1), 8'hFF, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_READ,    0, 8'h3C, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_SET,     BANK_W'(NUM_BANKS), 8'hFF, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_READ,    7, 8'hFF, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 0, IRQ_RISING));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, PIN_W'(NUM_PINS - 1), IRQ_FALLING));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 8, IRQ_ANY));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 9, IRQ_LOW));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 10, IRQ_HIGH));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 11, IRQ_SPARE_A));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 12, IRQ_SPARE_B));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 13, IRQ_DISABLE));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, PIN_W'(NUM_PINS), IRQ_RISING));
        send_item(mk(KIND_ATTACH,  0, 8'h00, '0, 63, IRQ_ANY));
        send_item(mk(KIND_SAMPLE,  0, 8'h00, '1, 0, IRQ_DISABLE));
        send_item(mk(KIND_SAMPLE,  0, 8'h00, '0, 0, IRQ_DISABLE));
        send_item(mk(KIND_DETACH,  0, 8'h00, '0, 8, IRQ_DISABLE));
        send_item(mk(KIND_SAMPLE,  0, 8'h00, 40'h55_5555_5555, 0, IRQ_DISABLE));
        send_item(mk(KIND_DETACH,  0, 8'h00, '0, 63, IRQ_DISABLE));
        send_item(mk(KIND_SPARE_FIRST, 7, 8'hFF, '1, 63, IRQ_SPARE_B));
        send_item(mk(KIND_SPARE_LAST,  0, 8'hFF, '1, 0, IRQ_HIGH));

        run_random(PHASE_ITEMS, 17, 76, 1'b0);
        run_random(PHASE_ITEMS, 76, 17, 1'b1);
        run_random(PHASE_ITEMS, 0, 0, 1'b0);
        item_ch.valid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        if (sb.pending() != 0)
        begin
            $display("timeout: %0d result beats never arrived", sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            repeat (8) @(negedge clk);
            $display("covered %0d command beats, %0d result beats checked", sb.n_items,
                     sb.n_results);
            $display("  %0d device register writes, %0d samples with firing pins",
                     sb.n_writes, sb.n_fires);
            if (sb.n_fail == 0 && sb.pending() == 0)
                $display("SCOREBOARD CLEAN");
            else
            begin
                $display("%0d mismatches, %0d beats left pending", sb.n_fail, sb.pending());
                $display("SCOREBOARD MISMATCH");
            end
            $finish;
        end
    end

endmodule

// File: gpio_expander_shadow_irq.f
+incdir+hw/rtl
hw/rtl/gpx_pkg.sv
hw/rtl/gpx_if.sv
hw/rtl/gpx_state.sv
hw/rtl/gpio_expander_shadow_irq.sv
hw/rtl/gpx_checker.sv
tb/gpio_expander_shadow_irq_test.sv
